[hdl/snlag_pkg.sv]
// ----------------------------------------------------------------------------
// snlag_pkg: shared constants for the strided nested-loop address generator
// Item kind codes, configuration register indexes and the operand widths of
// the shared multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

package snlag_pkg;

  // Item kinds
  localparam logic [2:0] KIND_STEP    = 3'd0;
  localparam logic [2:0] KIND_EXTENT  = 3'd1;
  localparam logic [2:0] KIND_TSTRIDE = 3'd2;
  localparam logic [2:0] KIND_GSTRIDE = 3'd3;
  localparam logic [2:0] KIND_BASE    = 3'd4;
  localparam logic [2:0] KIND_START   = 3'd5;

  // Configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SUBS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_TENSORS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_GRADES  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_BYTES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_GRADE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_MASK  = 3'd5;

  // Shared multiplier: a 32-bit stride times a 23-bit scale
  // (element bytes times a 16-bit repeat count).
  localparam int MUL_A_W = 32;
  localparam int MUL_B_W = 23;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

`default_nettype wire

[hdl/strided_nested_loop_address_generator_unit.sv]
// ----------------------------------------------------------------------------
// strided_nested_loop_address_generator_unit: odometer address generator
// Steps loop subscripts of one level, moving tensor byte addresses and grade
// counters by their strides, and rewinds on overflow with carry.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_stall_o | kind, level, sub_index,
//          |           |                        | row_index, value
//  out     | output    | out_valid_o / out_stall_i | more, addr_*, grade_*
//  cfg     | input     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  A load item or an empty step passes through the final state before the
//  next acceptance. A step visits, for each subscript the carry reaches, the
//  evaluate and scale states and then one add state per tensor in use (at
//  least one): each subscript is scaled first, then the shared multiplier
//  makes one pass per tensor address. The finished item waits in the output
//  register; a stalled output holds the block in its final state only if a
//  second result is ready before the first is taken. Reset clears the
//  addresses, grades and loop indexes and restores the configuration
//  defaults; the tables are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module strided_nested_loop_address_generator_unit #(
  parameter int MAX_SUBSCRIPTS     = 8,
  parameter int MAX_TENSORS        = 4,
  parameter int MAX_GRADE_COUNTERS = 4,
  parameter int ADDR_WIDTH         = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input items
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic        level_i,
  input  wire logic [2:0]  sub_index_i,
  input  wire logic [1:0]  row_index_i,
  input  wire logic [31:0] value_i,
  // result items
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             more_o,
  output logic [31:0]      addr_zero_o,
  output logic [31:0]      addr_one_o,
  output logic [31:0]      addr_two_o,
  output logic [31:0]      addr_three_o,
  output logic [3:0]       grade_zero_o,
  output logic [3:0]       grade_one_o,
  output logic [3:0]       grade_two_o,
  output logic [3:0]       grade_three_o,
  // configuration writes
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [snlag_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [snlag_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int SIW = (MAX_SUBSCRIPTS > 1) ? $clog2(MAX_SUBSCRIPTS) : 1;
  localparam int TIW = (MAX_TENSORS > 1) ? $clog2(MAX_TENSORS) : 1;
  localparam int GIW = (MAX_GRADE_COUNTERS > 1) ? $clog2(MAX_GRADE_COUNTERS) : 1;
  localparam int FW  = SIW + 1;
  localparam int RAM_DEPTH = (2 ** TIW) * (2 ** SIW);
  localparam int RAW = TIW + SIW;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_EVAL  = 3'd1;
  localparam logic [2:0] ST_SCALE = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  // Configuration
  logic [3:0] num_subs_q;
  logic [2:0] num_tensors_q;
  logic [2:0] num_grades_q;
  logic [6:0] elem_bytes_q;
  logic [3:0] top_grade_q;
  logic [7:0] inner_mask_q;

  // Sequencer
  logic [2:0]     state_q;
  logic [SIW-1:0] k_q;
  logic [TIW-1:0] j_q;
  logic           lvl_q;
  logic           ovf_q;
  logic           more_q;
  logic           out_valid_q;

  // Architectural state
  logic [MAX_TENSORS-1:0][ADDR_WIDTH-1:0]       cur_addr_q;
  logic [MAX_GRADE_COUNTERS-1:0][3:0]           cur_grade_q;
  logic [MAX_SUBSCRIPTS-1:0][15:0]              loop_idx_q;
  logic [MAX_SUBSCRIPTS-1:0][15:0]              extent_q;
  logic [MAX_GRADE_COUNTERS-1:0][MAX_SUBSCRIPTS-1:0] gstride_q;
  logic [snlag_pkg::MUL_B_W-1:0]                scale_q;

  // Output register
  logic             out_more_q;
  logic [3:0][31:0] out_addr_q;
  logic [3:0][3:0]  out_grade_q;
  logic [3:0][31:0] snap_addr;
  logic [3:0][3:0]  snap_grade;

  logic accept;
  logic sub_ok, row_t_ok, row_g_ok;

  assign accept      = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign sub_ok      = (int'(sub_index_i) < MAX_SUBSCRIPTS);
  assign row_t_ok    = (int'(row_index_i) < MAX_TENSORS);
  assign row_g_ok    = (int'(row_index_i) < MAX_GRADE_COUNTERS);

  // ---------------------------------------------------------------------------
  // Subscript search: lowest subscript of the level at or after a start point.
  // ---------------------------------------------------------------------------
  logic [FW-1:0]  from_v;
  logic           lvl_sel;
  logic           found;
  logic [SIW-1:0] pick;

  always_comb begin
    logic lv;
    from_v  = (state_q == ST_IDLE) ? '0 : (FW'(k_q) + FW'(1));
    lvl_sel = (state_q == ST_IDLE) ? level_i : lvl_q;
    found   = 1'b0;
    pick    = '0;
    lv      = 1'b0;
    for (int k = MAX_SUBSCRIPTS - 1; k >= 0; k--) begin
      lv = (k < 8) ? inner_mask_q[3'(k)] : 1'b0;
      if ((k < int'(num_subs_q)) && (lv == lvl_sel) && (k >= int'(from_v))) begin
        found = 1'b1;
        pick  = SIW'(k);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Increment or rewind of the current subscript.
  // ---------------------------------------------------------------------------
  logic [15:0] ext_raw, ext, factor;
  logic [16:0] nxt;
  logic        carry;
  logic [3:0]  gfac;
  logic [MAX_GRADE_COUNTERS-1:0][3:0] grade_nx;

  always_comb begin
    logic [3:0] gd;
    ext_raw = extent_q[k_q];
    ext     = (ext_raw == 16'd0) ? 16'd1 : ext_raw;
    nxt     = {1'b0, loop_idx_q[k_q]} + 17'd1;
    carry   = !(nxt < {1'b0, ext});
    factor  = carry ? (ext - 16'd1) : 16'd1;
    gfac    = carry ? top_grade_q : 4'd1;
    gd      = '0;
    for (int j = 0; j < MAX_GRADE_COUNTERS; j++) begin
      gd          = gstride_q[j][k_q] ? gfac : 4'd0;
      grade_nx[j] = carry ? (cur_grade_q[j] - gd) : (cur_grade_q[j] + gd);
    end
  end

  // ---------------------------------------------------------------------------
  // Stride table and shared multiplier
  // ---------------------------------------------------------------------------
  logic                          ram_we;
  logic [RAW-1:0]                ram_waddr, ram_raddr;
  logic [TIW-1:0]                ram_row;
  logic [31:0]                   ram_rdata;
  logic                          mul_en;
  logic [snlag_pkg::MUL_A_W-1:0] mul_a;
  logic [snlag_pkg::MUL_B_W-1:0] mul_b;
  logic [snlag_pkg::MUL_P_W-1:0] mul_p;
  logic [ADDR_WIDTH-1:0]         delta;

  assign ram_we    = accept && (kind_i == snlag_pkg::KIND_TSTRIDE) && row_t_ok && sub_ok;
  assign ram_waddr = {TIW'(row_index_i), SIW'(sub_index_i)};
  assign ram_raddr = {ram_row, k_q};
  assign delta     = ADDR_WIDTH'(mul_p);

  // The read runs one tensor ahead of the multiplier.
  always_comb begin
    case (state_q)
      ST_EVAL:  ram_row = '0;
      ST_SCALE: ram_row = TIW'(1);
      default:  ram_row = j_q + TIW'(2);
    endcase
  end

  always_comb begin
    mul_en = (state_q == ST_EVAL) || (state_q == ST_SCALE) || (state_q == ST_ADD);
    case (state_q)
      ST_EVAL: begin
        mul_a = snlag_pkg::MUL_A_W'(factor);
        mul_b = snlag_pkg::MUL_B_W'(elem_bytes_q);
      end
      ST_SCALE: begin
        mul_a = ram_rdata;
        mul_b = mul_p[snlag_pkg::MUL_B_W-1:0];
      end
      default: begin
        mul_a = ram_rdata;
        mul_b = scale_q;
      end
    endcase
  end

  snlag_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_stride_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (value_i),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  snlag_mul u_mul (
    .clk_i  (clk_i),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  logic j_live, j_last;
  assign j_live = (int'(j_q) < int'(num_tensors_q)) && (int'(j_q) < MAX_TENSORS);
  assign j_last = ((int'(j_q) + 1) >= int'(num_tensors_q)) || ((int'(j_q) + 1) >= MAX_TENSORS);

  // ---------------------------------------------------------------------------
  // Sequencer and architectural state
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_subs_q    <= 4'd1;
      num_tensors_q <= 3'd1;
      num_grades_q  <= 3'd0;
      elem_bytes_q  <= 7'd8;
      top_grade_q   <= 4'd3;
      inner_mask_q  <= 8'd0;
      state_q       <= ST_IDLE;
      k_q           <= '0;
      j_q           <= '0;
      lvl_q         <= 1'b0;
      ovf_q         <= 1'b0;
      more_q        <= 1'b0;
      out_valid_q   <= 1'b0;
      cur_addr_q    <= '0;
      cur_grade_q   <= '0;
      loop_idx_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          snlag_pkg::CFG_NUM_SUBS:    num_subs_q    <= cfg_data_i[3:0];
          snlag_pkg::CFG_NUM_TENSORS: num_tensors_q <= cfg_data_i[2:0];
          snlag_pkg::CFG_NUM_GRADES:  num_grades_q  <= cfg_data_i[2:0];
          snlag_pkg::CFG_ELEM_BYTES:  elem_bytes_q  <= cfg_data_i[6:0];
          snlag_pkg::CFG_TOP_GRADE:   top_grade_q   <= cfg_data_i[3:0];
          snlag_pkg::CFG_INNER_MASK:  inner_mask_q  <= cfg_data_i;
          default: ;
        endcase
      end

      // The final state refills the output register itself.
      if (out_valid_q && !out_stall_i && (state_q != ST_FIN)) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            lvl_q   <= level_i;
            more_q  <= 1'b0;
            if ((kind_i == snlag_pkg::KIND_STEP) && found) begin
              k_q     <= pick;
              state_q <= ST_EVAL;
            end else begin
              state_q <= ST_FIN;
            end
            case (kind_i)
              snlag_pkg::KIND_BASE: begin
                if (row_t_ok) begin
                  cur_addr_q[TIW'(row_index_i)] <= ADDR_WIDTH'(value_i);
                end
              end
              snlag_pkg::KIND_START: begin
                if (row_g_ok) begin
                  cur_grade_q[GIW'(row_index_i)] <= value_i[3:0];
                end
              end
              default: ;
            endcase
          end
        end
        ST_EVAL: begin
          ovf_q          <= carry;
          loop_idx_q[k_q] <= carry ? 16'd0 : nxt[15:0];
          for (int j = 0; j < MAX_GRADE_COUNTERS; j++) begin
            if (j < int'(num_grades_q)) begin
              cur_grade_q[j] <= grade_nx[j];
            end
          end
          j_q     <= '0;
          state_q <= ST_SCALE;
        end
        ST_SCALE: begin
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          if (j_live) begin
            cur_addr_q[j_q] <= ovf_q ? (cur_addr_q[j_q] - delta)
                                     : (cur_addr_q[j_q] + delta);
          end
          if (j_last) begin
            // A rewind hands the carry to the next subscript of the level.
            if (!ovf_q) begin
              more_q  <= 1'b1;
              state_q <= ST_FIN;
            end else if (found) begin
              k_q     <= pick;
              state_q <= ST_EVAL;
            end else begin
              state_q <= ST_FIN;
            end
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_FIN: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Tables, scale latch and output snapshot (no reset needed)
  // ---------------------------------------------------------------------------
  for (genvar g = 0; g < 4; g++) begin : g_snap
    if (g < MAX_TENSORS) begin : g_addr_on
      assign snap_addr[g] = 32'(cur_addr_q[g]);
    end else begin : g_addr_off
      assign snap_addr[g] = '0;
    end
    if (g < MAX_GRADE_COUNTERS) begin : g_grade_on
      assign snap_grade[g] = cur_grade_q[g];
    end else begin : g_grade_off
      assign snap_grade[g] = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && (kind_i == snlag_pkg::KIND_EXTENT) && sub_ok) begin
      extent_q[SIW'(sub_index_i)] <= value_i[15:0];
    end
    if (accept && (kind_i == snlag_pkg::KIND_GSTRIDE) && row_g_ok && sub_ok) begin
      gstride_q[GIW'(row_index_i)][SIW'(sub_index_i)] <= value_i[0];
    end
    if (state_q == ST_SCALE) begin
      scale_q <= mul_p[snlag_pkg::MUL_B_W-1:0];
    end
    if ((state_q == ST_FIN) && (!out_valid_q || !out_stall_i)) begin
      out_more_q  <= more_q;
      out_addr_q  <= snap_addr;
      out_grade_q <= snap_grade;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign more_o        = out_more_q;
  assign addr_zero_o   = out_addr_q[0];
  assign addr_one_o    = out_addr_q[1];
  assign addr_two_o    = out_addr_q[2];
  assign addr_three_o  = out_addr_q[3];
  assign grade_zero_o  = out_grade_q[0];
  assign grade_one_o   = out_grade_q[1];
  assign grade_two_o   = out_grade_q[2];
  assign grade_three_o = out_grade_q[3];

`ifndef SYNTHESIS
  // An accepted item always starts work.
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q != ST_IDLE))
    else $error("accepted item did not leave idle");

  // The subscript under evaluation is one that is in use.
  a_eval_sub: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EVAL) |-> ((int'(k_q) < MAX_SUBSCRIPTS) && (int'(k_q) < int'(num_subs_q))))
    else $error("evaluating a subscript that is not in use");

  // The tensor counter never runs past the address bank.
  a_add_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |-> (int'(j_q) < MAX_TENSORS))
    else $error("tensor counter out of range");

  // A result appears only out of the final state.
  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_FIN))
    else $error("result raised outside the final state");
`endif

endmodule

`default_nettype wire

[hdl/snlag_ram.sv]
// ----------------------------------------------------------------------------
// snlag_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module snlag_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                        wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

[hdl/snlag_mul.sv]
// ----------------------------------------------------------------------------
// snlag_mul: shared registered multiplier
// Forms the stride scale and every per-tensor address delta in turn.
// ----------------------------------------------------------------------------
`default_nettype none

module snlag_mul (
  input  wire logic                          clk_i,
  input  wire logic                          en_i,
  input  wire logic [snlag_pkg::MUL_A_W-1:0] a_i,
  input  wire logic [snlag_pkg::MUL_B_W-1:0] b_i,
  output logic      [snlag_pkg::MUL_P_W-1:0] prod_o
);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_o <= snlag_pkg::MUL_P_W'(a_i) * snlag_pkg::MUL_P_W'(b_i);
    end
  end

endmodule

`default_nettype wire

[tb/strided_nested_loop_address_generator_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// strided_nested_loop_address_generator_unit_test: self-checking testbench
// Loads the extent, stride and base tables and steps both loop levels under
// several configurations. Each result is compared with a cycle-free model of
// the odometer that runs alongside. Both channels idle and stall at random.
// ----------------------------------------------------------------------------

module strided_nested_loop_address_generator_unit_test;

  // Kinds that the block ignores, and a register index that holds nothing.
  localparam logic [2:0] KIND_SPARE_LO = 3'd6;
  localparam logic [2:0] KIND_SPARE_HI = 3'd7;
  localparam logic [snlag_pkg::CFG_IDX_W-1:0] CFG_SPARE = 3'd7;
  localparam int SETTLE_CYCLES = 64;

  typedef struct packed {
    logic            more;
    logic [3:0][31:0] addr;
    logic [3:0][3:0]  grade;
  } odometer_view_t;

  class odometer_tracker;
    logic [3:0]  num_subs;
    logic [2:0]  num_tens;
    logic [2:0]  num_grds;
    logic [6:0]  elem_bytes;
    logic [3:0]  top_grade;
    logic [7:0]  inner_mask;
    logic [15:0] extent [8];
    logic [31:0] tstride [4][8];
    logic        gstride [4][8];
    bit          ext_known [8];
    bit          ts_known [4][8];
    bit          gs_known [4][8];
    logic [31:0] addr [4];
    logic [3:0]  grade [4];
    int unsigned loop_idx [8];
    odometer_view_t expected_views [$];
    int          mismatch_count;

    function new();
      num_subs = 1;
      num_tens = 1;
      num_grds = 0;
      elem_bytes = 8;
      top_grade = 3;
      inner_mask = 0;
      mismatch_count = 0;
      for (int k = 0; k < 8; k++) begin
        ext_known[k] = 0;
        extent[k] = '0;
        loop_idx[k] = 0;
        for (int j = 0; j < 4; j++) begin
          ts_known[j][k] = 0;
          gs_known[j][k] = 0;
          tstride[j][k] = '0;
          gstride[j][k] = 1'b0;
        end
      end
      for (int j = 0; j < 4; j++) begin
        addr[j] = '0;
        grade[j] = '0;
      end
    endfunction

    function int subs_used();
      return (num_subs > 8) ? 8 : int'(num_subs);
    endfunction

    function int tens_used();
      return (num_tens > 4) ? 4 : int'(num_tens);
    endfunction

    function int grds_used();
      return (num_grds > 4) ? 4 : int'(num_grds);
    endfunction

    function int next_sub(int from, bit lvl);
      for (int k = from; k < subs_used(); k++)
        if (inner_mask[k] == lvl) return k;
      return subs_used();
    endfunction

    function void advance(int k, logic [31:0] times, logic [3:0] gtimes, bit back);
      logic [31:0] d;
      logic [3:0]  g;
      for (int j = 0; j < tens_used(); j++) begin
        d = tstride[j][k] * 32'(elem_bytes) * times;
        addr[j] = back ? addr[j] - d : addr[j] + d;
      end
      for (int j = 0; j < grds_used(); j++) begin
        g = gstride[j][k] ? gtimes : 4'd0;
        grade[j] = back ? grade[j] - g : grade[j] + g;
      end
    endfunction

    // Odometer step: bump the lowest subscript of the level, carry on wrap.
    function bit step_level(bit lvl);
      int k;
      int unsigned lim;
      int unsigned nxt;
      k = next_sub(0, lvl);
      while (k < subs_used()) begin
        lim = (extent[k] == 0) ? 1 : extent[k];
        nxt = loop_idx[k] + 1;
        if (nxt < lim) begin
          loop_idx[k] = nxt;
          advance(k, 32'd1, 4'd1, 1'b0);
          return 1'b1;
        end
        advance(k, lim - 1, top_grade, 1'b1);
        loop_idx[k] = 0;
        k = next_sub(k + 1, lvl);
      end
      return 1'b0;
    endfunction

    // Finds a table entry that a step of this level would read before it
    // has ever been loaded.
    function bit missing_entry(bit lvl, output logic [2:0] kind, output logic [2:0] sub,
                               output logic [1:0] row);
      int k;
      int unsigned lim;
      kind = snlag_pkg::KIND_EXTENT;
      sub = '0;
      row = '0;
      k = next_sub(0, lvl);
      while (k < subs_used()) begin
        sub = 3'(k);
        if (!ext_known[k]) begin
          kind = snlag_pkg::KIND_EXTENT;
          return 1'b1;
        end
        for (int j = 0; j < tens_used(); j++)
          if (!ts_known[j][k]) begin
            kind = snlag_pkg::KIND_TSTRIDE;
            row = 2'(j);
            return 1'b1;
          end
        for (int j = 0; j < grds_used(); j++)
          if (!gs_known[j][k]) begin
            kind = snlag_pkg::KIND_GSTRIDE;
            row = 2'(j);
            return 1'b1;
          end
        lim = (extent[k] == 0) ? 1 : extent[k];
        if (loop_idx[k] + 1 < lim) return 1'b0;
        k = next_sub(k + 1, lvl);
      end
      return 1'b0;
    endfunction

    function void note_config(logic [snlag_pkg::CFG_IDX_W-1:0] idx,
                              logic [snlag_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        snlag_pkg::CFG_NUM_SUBS:    num_subs = data[3:0];
        snlag_pkg::CFG_NUM_TENSORS: num_tens = data[2:0];
        snlag_pkg::CFG_NUM_GRADES:  num_grds = data[2:0];
        snlag_pkg::CFG_ELEM_BYTES:  elem_bytes = data[6:0];
        snlag_pkg::CFG_TOP_GRADE:   top_grade = data[3:0];
        snlag_pkg::CFG_INNER_MASK:  inner_mask = data[7:0];
        default: ;
      endcase
    endfunction

    function void note_item(logic [2:0] kind, logic lvl, logic [2:0] sub, logic [1:0] row,
                            logic [31:0] val);
      odometer_view_t v;
      logic more;
      more = 1'b0;
      case (kind)
        snlag_pkg::KIND_STEP:    more = step_level(lvl);
        snlag_pkg::KIND_EXTENT: begin
          extent[sub] = val[15:0];
          ext_known[sub] = 1;
        end
        snlag_pkg::KIND_TSTRIDE: begin
          tstride[row][sub] = val;
          ts_known[row][sub] = 1;
        end
        snlag_pkg::KIND_GSTRIDE: begin
          gstride[row][sub] = val[0];
          gs_known[row][sub] = 1;
        end
        snlag_pkg::KIND_BASE:    addr[row] = val;
        snlag_pkg::KIND_START:   grade[row] = val[3:0];
        default: ;
      endcase
      v.more = more;
      for (int j = 0; j < 4; j++) begin
        v.addr[j] = addr[j];
        v.grade[j] = grade[j];
      end
      expected_views.push_back(v);
    endfunction

    function void report(string what, logic [31:0] got, logic [31:0] want);
      mismatch_count++;
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
    endfunction

    function void check_view(odometer_view_t got);
      odometer_view_t want;
      if (expected_views.size() == 0) begin
        report("result with nothing outstanding", {31'd0, got.more}, 32'd0);
        return;
      end
      want = expected_views.pop_front();
      if (got.more !== want.more) report("more", {31'd0, got.more}, {31'd0, want.more});
      for (int j = 0; j < 4; j++) begin
        if (got.addr[j] !== want.addr[j])
          report($sformatf("address %0d", j), got.addr[j], want.addr[j]);
        if (got.grade[j] !== want.grade[j])
          report($sformatf("grade %0d", j), {28'd0, got.grade[j]}, {28'd0, want.grade[j]});
      end
    endfunction

    function int pending();
      return expected_views.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = '0;
  logic        level = 1'b0;
  logic [2:0]  sub_index = '0;
  logic [1:0]  row_index = '0;
  logic [31:0] value = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        more;
  logic [31:0] addr_zero, addr_one, addr_two, addr_three;
  logic [3:0]  grade_zero, grade_one, grade_two, grade_three;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [snlag_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [snlag_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  bit          steady = 1'b0;

  odometer_tracker tracker = new();

  strided_nested_loop_address_generator_unit DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .level_i      (level),
    .sub_index_i  (sub_index),
    .row_index_i  (row_index),
    .value_i      (value),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .more_o       (more),
    .addr_zero_o  (addr_zero),
    .addr_one_o   (addr_one),
    .addr_two_o   (addr_two),
    .addr_three_o (addr_three),
    .grade_zero_o (grade_zero),
    .grade_one_o  (grade_one),
    .grade_two_o  (grade_two),
    .grade_three_o(grade_three),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= steady ? 1'b0 : ($urandom_range(99) < 37);
  end

  always @(posedge clk) begin
    odometer_view_t v;
    if (rst_n && out_valid && !out_stall) begin
      v.more = more;
      v.addr = {addr_three, addr_two, addr_one, addr_zero};
      v.grade = {grade_three, grade_two, grade_one, grade_zero};
      tracker.check_view(v);
    end
  end

  task automatic send_item(logic [2:0] k, logic lvl, logic [2:0] sub, logic [1:0] row,
                           logic [31:0] val);
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    kind <= k;
    level <= lvl;
    sub_index <= sub;
    row_index <= row;
    value <= val;
    do @(posedge clk); while (in_stall);
    tracker.note_item(k, lvl, sub, row, val);
  endtask

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_cfg(logic [snlag_pkg::CFG_IDX_W-1:0] idx,
                           logic [snlag_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.note_config(idx, data);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  task automatic program_phase(int ph);
    case (ph)
      0: begin
        write_cfg(snlag_pkg::CFG_NUM_SUBS, 8'd8);
        write_cfg(snlag_pkg::CFG_NUM_TENSORS, 8'd4);
        write_cfg(snlag_pkg::CFG_NUM_GRADES, 8'd4);
        write_cfg(snlag_pkg::CFG_ELEM_BYTES, 8'd1);
        write_cfg(snlag_pkg::CFG_TOP_GRADE, 8'd15);
        write_cfg(snlag_pkg::CFG_INNER_MASK, 8'h0F);
      end
      1: begin
        write_cfg(snlag_pkg::CFG_NUM_SUBS, 8'hFF);
        write_cfg(snlag_pkg::CFG_NUM_TENSORS, 8'hFF);
        write_cfg(snlag_pkg::CFG_NUM_GRADES, 8'hFF);
        write_cfg(snlag_pkg::CFG_ELEM_BYTES, 8'hFF);
        write_cfg(snlag_pkg::CFG_TOP_GRADE, 8'hFF);
        write_cfg(snlag_pkg::CFG_INNER_MASK, 8'hFF);
      end
      2: begin
        write_cfg(snlag_pkg::CFG_NUM_SUBS, 8'h00);
        write_cfg(snlag_pkg::CFG_NUM_TENSORS, 8'h00);
        write_cfg(snlag_pkg::CFG_NUM_GRADES, 8'h00);
        write_cfg(snlag_pkg::CFG_ELEM_BYTES, 8'h00);
        write_cfg(snlag_pkg::CFG_TOP_GRADE, 8'h00);
        write_cfg(snlag_pkg::CFG_INNER_MASK, 8'h00);
        write_cfg(CFG_SPARE, 8'hFF);
      end
      default: begin
        write_cfg(snlag_pkg::CFG_NUM_SUBS, ($urandom_range(3) == 0) ? 8'($urandom)
                                                          : 8'($urandom_range(1, 8)));
        write_cfg(snlag_pkg::CFG_NUM_TENSORS, 8'($urandom_range(1, 4)));
        write_cfg(snlag_pkg::CFG_NUM_GRADES, 8'($urandom_range(0, 4)));
        write_cfg(snlag_pkg::CFG_ELEM_BYTES, 8'($urandom_range(1, 64)));
        write_cfg(snlag_pkg::CFG_TOP_GRADE, 8'($urandom_range(0, 15)));
        write_cfg(snlag_pkg::CFG_INNER_MASK, 8'($urandom));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Mostly steps over small extents so that carries run deep; a step that
  // would read a table entry never loaded turns into that load instead.
  task automatic drive_random(output bit counted);
    int          pick;
    logic [2:0]  k;
    logic        lvl;
    logic [2:0]  sub;
    logic [1:0]  row;
    logic [31:0] val;
    logic [2:0]  miss_kind;
    logic [2:0]  miss_sub;
    logic [1:0]  miss_row;
    pick = $urandom_range(99);
    lvl = 1'($urandom);
    sub = 3'($urandom);
    row = 2'($urandom);
    val = $urandom;
    if (pick < 55) k = snlag_pkg::KIND_STEP;
    else if (pick < 67) begin
      k = snlag_pkg::KIND_EXTENT;
      if ($urandom_range(9) < 8) val = (val & 32'hFFFF_0000) | $urandom_range(0, 5);
    end else if (pick < 75) k = snlag_pkg::KIND_TSTRIDE;
    else if (pick < 82) k = snlag_pkg::KIND_GSTRIDE;
    else if (pick < 88) k = snlag_pkg::KIND_BASE;
    else if (pick < 94) k = snlag_pkg::KIND_START;
    else k = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
    if (k == snlag_pkg::KIND_STEP &&
        tracker.missing_entry(lvl, miss_kind, miss_sub, miss_row)) begin
      k = miss_kind;
      sub = miss_sub;
      row = miss_row;
      if (k == snlag_pkg::KIND_EXTENT) val = ($urandom & 32'hFFFF_0000) | $urandom_range(1, 4);
    end
    counted = (k != KIND_SPARE_LO) && (k != KIND_SPARE_HI);
    send_item(k, lvl, sub, row, val);
  endtask

  initial begin
    int phase_items [6] = '{90, 40, 30, 110, 110, 120};
    int done;
    bit counted;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset configuration: one outer subscript.
    send_item(snlag_pkg::KIND_STEP, 1'b1, 3'd0, 2'd0, 32'd0);           // empty level
    send_item(KIND_SPARE_LO, 1'b0, 3'd7, 2'd3, 32'hFFFF_FFFF);
    send_item(KIND_SPARE_HI, 1'b1, 3'd0, 2'd0, 32'd0);
    send_item(snlag_pkg::KIND_EXTENT, 1'b0, 3'd0, 2'd0, 32'd0);
    send_item(snlag_pkg::KIND_TSTRIDE, 1'b0, 3'd0, 2'd0, 32'hFFFF_FFFF);
    send_item(snlag_pkg::KIND_STEP, 1'b0, 3'd0, 2'd0, 32'd0);           // zero extent
    send_item(snlag_pkg::KIND_BASE, 1'b0, 3'd0, 2'd0, 32'hFFFF_FFF8);
    send_item(snlag_pkg::KIND_BASE, 1'b0, 3'd0, 2'd3, 32'hA5A5_5A5A);
    send_item(snlag_pkg::KIND_START, 1'b0, 3'd0, 2'd3, 32'hFFFF_FFFF);
    send_item(snlag_pkg::KIND_EXTENT, 1'b0, 3'd0, 2'd0, 32'hFFFF_0003);
    repeat (3) send_item(snlag_pkg::KIND_STEP, 1'b0, 3'd0, 2'd0, 32'd0);
    repeat (2) send_item(snlag_pkg::KIND_STEP, 1'b0, 3'd0, 2'd0, 32'd0);
    // The index now sits at the old extent's end; shrinking it forces a wrap.
    send_item(snlag_pkg::KIND_EXTENT, 1'b0, 3'd0, 2'd0, 32'd2);
    send_item(snlag_pkg::KIND_STEP, 1'b0, 3'd0, 2'd0, 32'd0);
    send_item(snlag_pkg::KIND_GSTRIDE, 1'b0, 3'd0, 2'd0, 32'hFFFF_FFFF);
    send_item(snlag_pkg::KIND_EXTENT, 1'b0, 3'd0, 2'd0, 32'h0000_FFFF);
    send_item(snlag_pkg::KIND_STEP, 1'b0, 3'd0, 2'd0, 32'd0);
    send_item(snlag_pkg::KIND_TSTRIDE, 1'b0, 3'd7, 2'd3, 32'h8000_0001);
    send_item(snlag_pkg::KIND_STEP, 1'b1, 3'd0, 2'd0, 32'd0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_drained();
      program_phase(ph);
      steady = (ph == 3);
      done = 0;
      while (done < phase_items[ph]) begin
        drive_random(counted);
        if (counted) done++;
      end
    end
    steady = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[filelist.f]
hdl/snlag_pkg.sv
hdl/snlag_ram.sv
hdl/snlag_mul.sv
hdl/strided_nested_loop_address_generator_unit.sv
tb/strided_nested_loop_address_generator_unit_test.sv
